>>> rtl/itl_pkg.sv
`default_nettype none

package itl_pkg;

    // curve table geometry
    localparam int INDEX_BITS  = 12;
    localparam int FRAC_BITS   = 24;
    localparam int SHIFT_BITS  = FRAC_BITS - INDEX_BITS;
    localparam int TABLE_LAST  = 1 << INDEX_BITS;
    localparam int TABLE_DEPTH = TABLE_LAST + 1;

    // entries are split into an even and an odd bank so that neighbours read together
    localparam int EVEN_DEPTH = TABLE_LAST / 2 + 1;
    localparam int ODD_DEPTH  = TABLE_LAST / 2;
    localparam int EVEN_AW    = $clog2(EVEN_DEPTH);
    localparam int ODD_AW     = $clog2(ODD_DEPTH);

    // field widths
    localparam int ENTRY_IDX_W = 13;
    localparam int ENTRY_W     = 25;
    localparam int PIX_W       = 28;
    localparam int M_W         = PIX_W - 1;
    localparam int PROD_W      = M_W + 1 + ENTRY_W + 1;
    localparam int SUM_W       = PROD_W + 1;

    // stream packing
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 3 * PIX_W;
    localparam int IN_PAD_W    = IN_TDATA_W - ENTRY_IDX_W - ENTRY_W - 3 * PIX_W;
    localparam int IDX_LSB     = 0;
    localparam int VAL_LSB     = IDX_LSB + ENTRY_IDX_W;
    localparam int RED_LSB     = VAL_LSB + ENTRY_W;
    localparam int GRN_LSB     = RED_LSB + PIX_W;
    localparam int BLU_LSB     = GRN_LSB + PIX_W;

    // item kinds carried in tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // 1.0 in the pixel format
    localparam logic signed [PIX_W-1:0] PIX_ONE = PIX_W'(1) << FRAC_BITS;

    // table write from a load transaction
    typedef struct packed {
        logic                   we;
        logic [ENTRY_IDX_W-1:0] addr;
        logic [ENTRY_W-1:0]     data;
    } t_wr_port;

    // per-stage advance strobes
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_pipe_en;

endpackage

`default_nettype wire

>>> rtl/itl_ram.sv
`default_nettype none

module itl_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/itl_chan.sv
`default_nettype none

module itl_chan (
    input  wire logic                            i_clk,
    input  wire itl_pkg::t_pipe_en               i_en,
    input  wire itl_pkg::t_wr_port               i_wr,
    input  wire logic signed [itl_pkg::PIX_W-1:0] i_pix,
    output logic signed [itl_pkg::PIX_W-1:0]     o_res
);

    logic [itl_pkg::INDEX_BITS-1:0] idx;
    logic [itl_pkg::M_W-1:0]        mul;
    logic                           use_b;
    logic [itl_pkg::EVEN_AW-1:0]    even_raddr;
    logic [itl_pkg::ODD_AW-1:0]     odd_raddr;
    logic [itl_pkg::ENTRY_W-1:0]    even_q;
    logic [itl_pkg::ENTRY_W-1:0]    odd_q;

    logic [itl_pkg::M_W-1:0]        r_s1_mul;
    logic                           r_s1_use_b;
    logic                           r_s1_swap;

    logic [itl_pkg::ENTRY_W-1:0]    ent_a;
    logic [itl_pkg::ENTRY_W-1:0]    ent_b;
    logic signed [itl_pkg::ENTRY_W:0] diff;
    logic [itl_pkg::ENTRY_W-1:0]    n_base;
    logic signed [itl_pkg::PROD_W-1:0] n_prod;

    logic [itl_pkg::ENTRY_W-1:0]    r_s2_base;
    logic signed [itl_pkg::PROD_W-1:0] r_s2_prod;

    logic signed [itl_pkg::SUM_W-1:0]  sum;
    logic                              ovf;
    logic signed [itl_pkg::PIX_W-1:0]  n_res;
    logic signed [itl_pkg::PIX_W-1:0]  r_res;

    // segment select: clamp at zero, interpolate below one, extrapolate above
    always_comb begin
        idx   = '0;
        mul   = '0;
        use_b = 1'b0;
        if (i_pix[itl_pkg::PIX_W-1] || (i_pix == '0)) begin
            idx = '0;
        end else if (i_pix >= itl_pkg::PIX_ONE) begin
            idx   = itl_pkg::INDEX_BITS'(itl_pkg::TABLE_LAST - 1);
            mul   = itl_pkg::M_W'(i_pix - itl_pkg::PIX_ONE);
            use_b = 1'b1;
        end else begin
            idx = i_pix[itl_pkg::FRAC_BITS-1:itl_pkg::SHIFT_BITS];
            mul = itl_pkg::M_W'(i_pix[itl_pkg::SHIFT_BITS-1:0]);
        end
    end

    // neighbouring entries sit in opposite banks
    assign even_raddr = itl_pkg::EVEN_AW'(({1'b0, idx} + 1'b1) >> 1);
    assign odd_raddr  = itl_pkg::ODD_AW'(idx >> 1);

    itl_ram #(
        .WIDTH (itl_pkg::ENTRY_W),
        .DEPTH (itl_pkg::EVEN_DEPTH)
    ) u_even (
        .i_clk   (i_clk),
        .i_we    (i_wr.we && !i_wr.addr[0]),
        .i_waddr (itl_pkg::EVEN_AW'(i_wr.addr >> 1)),
        .i_wdata (i_wr.data),
        .i_re    (i_en.s1),
        .i_raddr (even_raddr),
        .o_rdata (even_q)
    );

    itl_ram #(
        .WIDTH (itl_pkg::ENTRY_W),
        .DEPTH (itl_pkg::ODD_DEPTH)
    ) u_odd (
        .i_clk   (i_clk),
        .i_we    (i_wr.we && i_wr.addr[0]),
        .i_waddr (itl_pkg::ODD_AW'(i_wr.addr >> 1)),
        .i_wdata (i_wr.data),
        .i_re    (i_en.s1),
        .i_raddr (odd_raddr),
        .o_rdata (odd_q)
    );

    // stage 1 side data alongside the table read
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_s1_mul   <= mul;
            r_s1_use_b <= use_b;
            r_s1_swap  <= idx[0];
        end
    end

    // slope times offset: fraction for interpolation, distance past one otherwise
    assign ent_a  = r_s1_swap ? odd_q : even_q;
    assign ent_b  = r_s1_swap ? even_q : odd_q;
    assign diff   = $signed({1'b0, ent_b}) - $signed({1'b0, ent_a});
    assign n_base = r_s1_use_b ? ent_b : ent_a;
    assign n_prod = $signed({1'b0, r_s1_mul}) * diff;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s2_base <= n_base;
            r_s2_prod <= n_prod;
        end
    end

    // floor shift, add base and saturate
    assign sum = itl_pkg::SUM_W'(r_s2_prod >>> itl_pkg::SHIFT_BITS)
               + itl_pkg::SUM_W'(r_s2_base);
    assign ovf = (sum[itl_pkg::SUM_W-1:itl_pkg::PIX_W-1] != '0)
              && (sum[itl_pkg::SUM_W-1:itl_pkg::PIX_W-1] != '1);

    always_comb begin
        if (!ovf) begin
            n_res = sum[itl_pkg::PIX_W-1:0];
        end else if (sum[itl_pkg::SUM_W-1]) begin
            n_res = {1'b1, {(itl_pkg::PIX_W-1){1'b0}}};
        end else begin
            n_res = {1'b0, {(itl_pkg::PIX_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

>>> rtl/interpolated_tone_lut.sv
`default_nettype none
// channel     dir  handshake                            payload
// s_axis      in   i_s_axis_tvalid / o_s_axis_tready    tdata: index, value, r, g, b; tuser: cmd
// m_axis      out  o_m_axis_tvalid / i_m_axis_tready    tdata: r, g, b
//
// one transaction per clock in both directions when the output is not stalled
// pixel results pass three registered stages after acceptance: table read, multiply, add/saturate
// an in-range load writes one entry in every channel's table copy; no load gives a result
// reset clears only the stage valid flags; the table holds nothing until loaded
// a stall on m_axis fills the three stages before s_axis drops tready

module interpolated_tone_lut (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // entry_index, entry_value, pixel_red, pixel_green, pixel_blue, zero pad
    input  wire logic [itl_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // cmd
    input  wire logic                                i_s_axis_tuser,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // out_red, out_green, out_blue, zero pad
    output logic [itl_pkg::OUT_TDATA_W-1:0]          o_m_axis_tdata
);

    itl_pkg::t_pipe_en en;
    itl_pkg::t_wr_port wr;
    logic              in_acc;
    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic [itl_pkg::ENTRY_IDX_W-1:0] in_idx;
    logic signed [itl_pkg::PIX_W-1:0] res_red;
    logic signed [itl_pkg::PIX_W-1:0] res_green;
    logic signed [itl_pkg::PIX_W-1:0] res_blue;

    // each stage moves when the next one is empty or moving
    assign en.s3 = !r_v3 || i_m_axis_tready;
    assign en.s2 = !r_v2 || en.s3;
    assign en.s1 = !r_v1 || en.s2;

    assign o_s_axis_tready = en.s1;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // table write, out of range indices dropped
    assign in_idx  = i_s_axis_tdata[itl_pkg::IDX_LSB +: itl_pkg::ENTRY_IDX_W];
    assign wr.we   = in_acc && (i_s_axis_tuser == itl_pkg::CMD_LOAD)
                  && (in_idx < itl_pkg::ENTRY_IDX_W'(itl_pkg::TABLE_DEPTH));
    assign wr.addr = in_idx;
    assign wr.data = i_s_axis_tdata[itl_pkg::VAL_LSB +: itl_pkg::ENTRY_W];

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en.s1) begin
                r_v1 <= in_acc && (i_s_axis_tuser == itl_pkg::CMD_PIXEL);
            end
            if (en.s2) begin
                r_v2 <= r_v1;
            end
            if (en.s3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // one datapath per colour
    itl_chan u_red (
        .i_clk (i_clk),
        .i_en  (en),
        .i_wr  (wr),
        .i_pix ($signed(i_s_axis_tdata[itl_pkg::RED_LSB +: itl_pkg::PIX_W])),
        .o_res (res_red)
    );

    itl_chan u_green (
        .i_clk (i_clk),
        .i_en  (en),
        .i_wr  (wr),
        .i_pix ($signed(i_s_axis_tdata[itl_pkg::GRN_LSB +: itl_pkg::PIX_W])),
        .o_res (res_green)
    );

    itl_chan u_blue (
        .i_clk (i_clk),
        .i_en  (en),
        .i_wr  (wr),
        .i_pix ($signed(i_s_axis_tdata[itl_pkg::BLU_LSB +: itl_pkg::PIX_W])),
        .o_res (res_blue)
    );

    assign o_m_axis_tvalid = r_v3;
    assign o_m_axis_tdata  = {{itl_pkg::OUT_PAD_W{1'b0}}, res_blue, res_green, res_red};

`ifndef ASSERT_OFF
    // a pixel transaction always enters the first stage
    a_pixel_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_s_axis_tuser == itl_pkg::CMD_PIXEL)) |=> r_v1)
        else $error("pixel transaction lost at stage 1");

    // a load transaction never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_s_axis_tuser == itl_pkg::CMD_LOAD)) |=> !r_v1)
        else $error("load transaction created a result");

    // input is held off only when every stage is full and the output stalls
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_v1 && r_v2 && r_v3 && !i_m_axis_tready))
        else $error("input stalled with room in the pipeline");

    // a stalled stage 2 item is not overwritten or dropped
    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !en.s2) |=> r_v2)
        else $error("stage 2 item dropped during a stall");
`endif

endmodule

`default_nettype wire

>>> bench/tone_curve_checker.sv
`timescale 1ns / 100ps
`default_nettype none

module tone_curve_checker
    import itl_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    input  wire logic                   i_s_axis_tready,
    // entry_index, entry_value, pixel_red, pixel_green, pixel_blue, zero pad
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // cmd
    input  wire logic                   i_s_axis_tuser,
    input  wire logic                   i_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // out_red, out_green, out_blue, zero pad
    input  wire logic [OUT_TDATA_W-1:0] i_m_axis_tdata,
    output logic [31:0]                 o_fail_count,
    output logic [31:0]                 o_pending
);

    localparam longint ONE_LEVEL  = longint'(1) << FRAC_BITS;
    localparam longint SEG_SPAN   = longint'(1) << SHIFT_BITS;
    localparam longint LEVEL_MAX  = (longint'(1) << (PIX_W - 1)) - 1;
    localparam longint LEVEL_MIN  = -(longint'(1) << (PIX_W - 1));
    localparam int     PRINT_CAP  = 100;

    typedef struct packed {
        logic signed [PIX_W-1:0] red;
        logic signed [PIX_W-1:0] green;
        logic signed [PIX_W-1:0] blue;
    } t_rgb_level;

    // private copy of the curve table, written by every in-range load transaction
    logic [ENTRY_W-1:0] shadow_curve [TABLE_DEPTH];
    t_rgb_level         expected_rgb [$];
    t_rgb_level         got_rgb;
    t_rgb_level         want_rgb;
    logic [ENTRY_IDX_W-1:0] load_idx;
    int unsigned        mismatches = 0;
    int unsigned        outstanding = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = outstanding;

    task automatic report_mismatch(input string what, input logic signed [PIX_W-1:0] want,
                                   input logic signed [PIX_W-1:0] got);
        if (mismatches < PRINT_CAP)
            $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    // one channel through the curve: clamp low, interpolate, or extend the last slope
    function automatic logic signed [PIX_W-1:0] tone_map_level(
            input logic signed [PIX_W-1:0] level);
        longint lvl;
        longint last_v;
        longint prev_v;
        longint frac;
        longint mixed;
        int unsigned seg;
        lvl = longint'(level);
        if (lvl <= 0) begin
            mixed = longint'(shadow_curve[0]);
        end else if (lvl >= ONE_LEVEL) begin
            last_v = longint'(shadow_curve[TABLE_LAST]);
            prev_v = longint'(shadow_curve[TABLE_LAST-1]);
            // arithmetic shift floors the slope term
            mixed  = last_v + (((lvl - ONE_LEVEL) * (last_v - prev_v)) >>> SHIFT_BITS);
            if (mixed > LEVEL_MAX)
                mixed = LEVEL_MAX;
            else if (mixed < LEVEL_MIN)
                mixed = LEVEL_MIN;
        end else begin
            seg   = int'(lvl >> SHIFT_BITS);
            frac  = lvl & (SEG_SPAN - 1);
            mixed = (longint'(shadow_curve[seg]) * (SEG_SPAN - frac)
                     + longint'(shadow_curve[seg+1]) * frac) >>> SHIFT_BITS;
        end
        return mixed[PIX_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // result side first: a result never belongs to the transaction of the same edge
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_rgb.red   = i_m_axis_tdata[0         +: PIX_W];
                got_rgb.green = i_m_axis_tdata[PIX_W     +: PIX_W];
                got_rgb.blue  = i_m_axis_tdata[2 * PIX_W +: PIX_W];
                if (expected_rgb.size() == 0) begin
                    report_mismatch("unexpected result, red", '0, got_rgb.red);
                end else begin
                    want_rgb = expected_rgb.pop_front();
                    if (got_rgb.red !== want_rgb.red)
                        report_mismatch("out_red", want_rgb.red, got_rgb.red);
                    if (got_rgb.green !== want_rgb.green)
                        report_mismatch("out_green", want_rgb.green, got_rgb.green);
                    if (got_rgb.blue !== want_rgb.blue)
                        report_mismatch("out_blue", want_rgb.blue, got_rgb.blue);
                end
            end
            // input side: loads update the copy, pixels queue a prediction
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                if (i_s_axis_tuser == CMD_PIXEL) begin
                    want_rgb.red   = tone_map_level(i_s_axis_tdata[RED_LSB +: PIX_W]);
                    want_rgb.green = tone_map_level(i_s_axis_tdata[GRN_LSB +: PIX_W]);
                    want_rgb.blue  = tone_map_level(i_s_axis_tdata[BLU_LSB +: PIX_W]);
                    expected_rgb.push_back(want_rgb);
                end else begin
                    load_idx = i_s_axis_tdata[IDX_LSB +: ENTRY_IDX_W];
                    if (load_idx < TABLE_DEPTH)
                        shadow_curve[load_idx] = i_s_axis_tdata[VAL_LSB +: ENTRY_W];
                end
            end
            outstanding <= expected_rgb.size();
        end
    end

endmodule

`default_nettype wire

>>> bench/tb_interpolated_tone_lut.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_interpolated_tone_lut;
    import itl_pkg::*;

    localparam int ENTRY_MAX      = 1 << FRAC_BITS;
    localparam int LEVEL_ONE      = 1 << FRAC_BITS;
    localparam int LEVEL_TOP      = (1 << (PIX_W - 1)) - 1;
    localparam int LEVEL_BOTTOM   = -(1 << (PIX_W - 1));
    localparam int PHASE_ITEMS    = 500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = CMD_LOAD;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [31:0]            fail_count;
    logic [31:0]            pending;

    int send_idle_pct = 33;
    int recv_idle_pct = 72;

    initial begin
        forever #5 clk = ~clk;
    end

    interpolated_tone_lut DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    tone_curve_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // result side back-pressure
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one transaction on the input channel, with random gaps ahead of it
    task automatic drive_transaction(input logic kind, input logic [ENTRY_IDX_W-1:0] idx,
                                     input logic [ENTRY_W-1:0] val,
                                     input logic [PIX_W-1:0] red,
                                     input logic [PIX_W-1:0] green,
                                     input logic [PIX_W-1:0] blue);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[IDX_LSB +: ENTRY_IDX_W] = idx;
        word[VAL_LSB +: ENTRY_W]     = val;
        word[RED_LSB +: PIX_W]       = red;
        word[GRN_LSB +: PIX_W]       = green;
        word[BLU_LSB +: PIX_W]       = blue;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
    endtask

    // unused fields of each kind carry random bits
    task automatic load_entry(input int idx, input int val);
        drive_transaction(CMD_LOAD, ENTRY_IDX_W'(idx), ENTRY_W'(val), PIX_W'($urandom),
                          PIX_W'($urandom), PIX_W'($urandom));
    endtask

    task automatic send_pixel(input int red, input int green, input int blue);
        drive_transaction(CMD_PIXEL, ENTRY_IDX_W'($urandom), ENTRY_W'($urandom),
                          PIX_W'(red), PIX_W'(green), PIX_W'(blue));
    endtask

    function automatic int random_entry();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return 0;
        if (pick < 10)
            return ENTRY_MAX;
        return $urandom_range(ENTRY_MAX, 0);
    endfunction

    // channel levels weighted towards the interpolation range
    function automatic int random_level();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return $urandom_range(LEVEL_ONE - 1, 1);
        if (pick < 65)
            return -int'($urandom_range(1 << (PIX_W - 1), 1));
        if (pick < 68)
            return 0;
        if (pick < 71)
            return LEVEL_ONE;
        if (pick < 82)
            return LEVEL_ONE + int'($urandom_range(1 << 20, 0));
        if (pick < 97)
            return int'({{(32 - PIX_W){1'b0}}, PIX_W'($urandom)} << (32 - PIX_W))
                   >>> (32 - PIX_W);
        return (pick[0]) ? LEVEL_TOP : LEVEL_BOTTOM;
    endfunction

    // random mix of loads, ignored loads and pixels
    task automatic random_traffic(input int count);
        int done;
        int pick;
        int idx;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                if ($urandom_range(3) == 0)
                    idx = (pick[0]) ? TABLE_LAST - int'(pick[1]) : int'(pick[1]);
                else
                    idx = $urandom_range(TABLE_LAST, 0);
                load_entry(idx, random_entry());
                done++;
            end else if (pick < 23) begin
                load_entry($urandom_range((1 << ENTRY_IDX_W) - 1, TABLE_DEPTH), random_entry());
            end else begin
                send_pixel(random_level(), random_level(), random_level());
                done++;
            end
        end
    endtask

    // watchdog on cycles with no transaction on either channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL interpolated_tone_lut");
        $finish;
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole table so that no pixel reads an unwritten entry
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (k == 0 || k == TABLE_LAST - 1)
                load_entry(k, 0);
            else if (k == 1 || k == TABLE_LAST)
                load_entry(k, ENTRY_MAX);
            else
                load_entry(k, random_entry());
        end

        // clamp at or below zero, interpolation edges, steep rising extrapolation
        send_pixel(0, -1, LEVEL_BOTTOM);
        send_pixel(1, LEVEL_ONE - 1, 4096);
        send_pixel(LEVEL_ONE, LEVEL_ONE + 1, LEVEL_TOP);
        // loads beyond the table are dropped
        load_entry(TABLE_DEPTH, ENTRY_MAX);
        load_entry((1 << ENTRY_IDX_W) - 1, ENTRY_MAX);
        send_pixel(LEVEL_ONE + 3, LEVEL_TOP, 1 << 26);
        // falling last slope saturates low
        load_entry(TABLE_LAST, 0);
        load_entry(TABLE_LAST - 1, ENTRY_MAX);
        send_pixel(LEVEL_ONE, LEVEL_TOP, LEVEL_ONE + 4095);
        // shallow falling slope checks rounding towards minus infinity
        load_entry(TABLE_LAST - 1, 5);
        send_pixel(LEVEL_ONE + 1, LEVEL_ONE + 4095, LEVEL_ONE + 8191);
        load_entry(TABLE_LAST, 10);
        send_pixel(LEVEL_ONE + 1, LEVEL_ONE + 4097, LEVEL_TOP);
        // entry zero at full scale
        load_entry(0, ENTRY_MAX);
        send_pixel(LEVEL_BOTTOM, 0, -1);
        send_pixel(1 << 23, 12345, LEVEL_ONE - 4096);

        random_traffic(PHASE_ITEMS);
        send_idle_pct = 72;
        recv_idle_pct = 33;
        random_traffic(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(PHASE_ITEMS);
        s_tvalid <= 1'b0;

        // drain, then allow for stray results
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS interpolated_tone_lut");
        else
            $display("FAIL interpolated_tone_lut");
        $finish;
    end

endmodule

`default_nettype wire
